// ----- design/sslex_pkg.sv -----
// Package for the script source lexer: token kind codes and the token and
// batch structures passed between the lexer core and the result queue.
// Depends on nothing.
`timescale 1ns / 1ps

package sslex_pkg;

   localparam int TOKENS_MAX = 3;

   localparam logic [4:0] KIND_END          = 5'd0;
   localparam logic [4:0] KIND_ILLEGAL      = 5'd1;
   localparam logic [4:0] KIND_IDENT        = 5'd2;
   localparam logic [4:0] KIND_NUMBER       = 5'd3;
   localparam logic [4:0] KIND_STRING       = 5'd4;
   localparam logic [4:0] KIND_OP_BASE      = 5'd5;
   localparam logic [4:0] KIND_COLON        = 5'd13;
   localparam logic [4:0] KIND_SEMICOLON    = 5'd14;
   localparam logic [4:0] KIND_LPAREN       = 5'd15;
   localparam logic [4:0] KIND_RPAREN       = 5'd16;
   localparam logic [4:0] KIND_COMMA        = 5'd17;
   localparam logic [4:0] KIND_PLUS         = 5'd18;
   localparam logic [4:0] KIND_MINUS        = 5'd19;
   localparam logic [4:0] KIND_STAR         = 5'd20;
   localparam logic [4:0] KIND_SLASH        = 5'd21;
   localparam logic [4:0] KIND_LBRACE       = 5'd22;
   localparam logic [4:0] KIND_RBRACE       = 5'd23;
   localparam logic [4:0] KIND_DOT          = 5'd24;
   localparam logic [4:0] KIND_UNTERMINATED = 5'd25;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok2;
      token_type  tok1;
      token_type  tok0;
   } batch_type;

endpackage

// ----- design/script_source_lexer_top.sv -----
// Top level of the script source lexer: byte request channel, token
// response channel, lexer core and result queue.
// Depends on sslex_pkg, sslex_core and sslex_outq.
//
// Usage: one source byte per request transaction (req_source_byte with
// req_final_byte marking the last byte). Each byte yields zero to three
// tokens on the response channel, one token per transaction, with
// rsp_run_last set on the last token of that byte. A zero byte or the
// final flag closes any open token and gives an end token; later bytes
// are taken and ignored until reset.
// A token appears on the response channel in the cycle after its byte
// is taken. Throughput: one byte per cycle while each byte gives at most
// one token and the receiver takes it; a byte that gives more tokens holds
// the request channel until the three-entry result queue has drained to
// its last token, before the next byte's tokens load.
// Reset (synchronous, active high) returns the lexer to idle at offset
// zero and empties the queue. When the receiver stalls, the queue holds
// its tokens and req_ready stays low while any token is waiting.
`timescale 1ns / 1ps

module script_source_lexer_top #(
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_source_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_run_last
);

   sslex_pkg::batch_type batch;
   sslex_pkg::token_type head;
   logic                 accept;

   assign accept = req_valid && req_ready;

   sslex_core #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_byte (req_source_byte),
      .final_byte  (req_final_byte),
      .batch       (batch)
   );

   sslex_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .batch      (batch),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .head       (head),
      .can_accept (req_ready)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_run_last     = head.last;

`ifndef NO_ASSERTIONS
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == sslex_pkg::KIND_END |->
         rsp_run_last && rsp_token_length == 16'd0)
      else $error("End token must be the last token of its byte with zero length.");

   a_nothing_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_token_kind == sslex_pkg::KIND_END |=> !rsp_valid)
      else $error("A token followed the end token.");

   a_illegal_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == sslex_pkg::KIND_ILLEGAL |-> rsp_token_length == 16'd1)
      else $error("Illegal token must have length one.");
`endif

endmodule

// ----- design/sslex_core.sv -----
// Lexer core: mode, pending operator and offset registers, plus the
// single-pass logic that turns one byte into up to three tokens.
// Depends on sslex_pkg.
`timescale 1ns / 1ps

module sslex_core #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           source_byte,
   input  logic                 final_byte,
   output sslex_pkg::batch_type batch
);

   localparam int WIDE = OFFSET_BITS + 16;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_DQ,
      MODE_SQ,
      MODE_OP
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [1:0]             pend_ff, pend_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   ended_ff, ended_in;

   sslex_pkg::token_type   toks [0:2];
   logic [1:0]             n;

   function automatic logic alpha_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic decimal_char(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [15:0] sat_field(input logic [OFFSET_BITS-1:0] v);
      logic [WIDE-1:0] wide;
      wide = WIDE'(v);
      return (wide > WIDE'(16'hFFFF)) ? 16'hFFFF : wide[15:0];
   endfunction

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (v == '1) ? v : v + OFFSET_BITS'(1);
   endfunction

   function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] from,
                                                   input logic [OFFSET_BITS-1:0] upto);
      return (upto > from) ? upto - from : '0;
   endfunction

   function automatic sslex_pkg::token_type make_token(input logic [4:0] kind,
                                                       input logic [OFFSET_BITS-1:0] start,
                                                       input logic [OFFSET_BITS-1:0] len);
      sslex_pkg::token_type t;
      t.kind   = kind;
      t.start  = sat_field(start);
      t.length = sat_field(len);
      t.last   = 1'b0;
      return t;
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         ":":     k = sslex_pkg::KIND_COLON;
         ";":     k = sslex_pkg::KIND_SEMICOLON;
         "(":     k = sslex_pkg::KIND_LPAREN;
         ")":     k = sslex_pkg::KIND_RPAREN;
         ",":     k = sslex_pkg::KIND_COMMA;
         "+":     k = sslex_pkg::KIND_PLUS;
         "-":     k = sslex_pkg::KIND_MINUS;
         "*":     k = sslex_pkg::KIND_STAR;
         "/":     k = sslex_pkg::KIND_SLASH;
         "{":     k = sslex_pkg::KIND_LBRACE;
         "}":     k = sslex_pkg::KIND_RBRACE;
         ".":     k = sslex_pkg::KIND_DOT;
         default: k = sslex_pkg::KIND_ILLEGAL;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] op_kind(input logic [1:0] pend, input logic with_eq);
      return sslex_pkg::KIND_OP_BASE + {2'b00, pend, with_eq};
   endfunction

   always_comb begin
      logic [OFFSET_BITS-1:0] pos;
      logic [OFFSET_BITS-1:0] pos_next;
      logic [OFFSET_BITS-1:0] flush_pos;
      logic                   reproc;
      logic                   flush_en;
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      start_in  = start_ff;
      offset_in = offset_ff;
      ended_in  = ended_ff;
      pos       = offset_ff;
      pos_next  = sat_inc(offset_ff);
      flush_pos = offset_ff;
      reproc    = 1'b0;
      flush_en  = 1'b0;
      n         = 2'd0;
      for (int i = 0; i < sslex_pkg::TOKENS_MAX; i++) begin
         toks[i] = '0;
      end

      if (accept && !ended_ff) begin
         if (source_byte == 8'd0) begin
            flush_en  = 1'b1;
            flush_pos = pos;
            ended_in  = 1'b1;
         end else begin
            unique case (mode_ff)
               MODE_IDENT: begin
                  if (!(alpha_char(source_byte) || decimal_char(source_byte))) begin
                     toks[n] = make_token(sslex_pkg::KIND_IDENT, start_ff, span(start_ff, pos));
                     n = n + 2'd1;
                     mode_in = MODE_IDLE;
                     reproc = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (!decimal_char(source_byte)) begin
                     toks[n] = make_token(sslex_pkg::KIND_NUMBER, start_ff, span(start_ff, pos));
                     n = n + 2'd1;
                     mode_in = MODE_IDLE;
                     reproc = 1'b1;
                  end
               end
               MODE_DQ, MODE_SQ: begin
                  if (source_byte == ((mode_ff == MODE_DQ) ? 8'h22 : 8'h27)) begin
                     toks[n] = make_token(sslex_pkg::KIND_STRING, start_ff, span(start_ff, pos));
                     n = n + 2'd1;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_OP: begin
                  if (source_byte == "=") begin
                     toks[n] = make_token(op_kind(pend_ff, 1'b1), start_ff, OFFSET_BITS'(2));
                  end else begin
                     toks[n] = make_token(op_kind(pend_ff, 1'b0), start_ff, OFFSET_BITS'(1));
                     reproc = 1'b1;
                  end
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
               end
               default: begin
                  mode_in = MODE_IDLE;
                  reproc = 1'b1;
               end
            endcase

            if (reproc) begin
               if (source_byte == " " || source_byte == 8'h0A ||
                   source_byte == 8'h09 || source_byte == 8'h0D) begin
                  mode_in = MODE_IDLE;
               end else if (alpha_char(source_byte)) begin
                  mode_in  = MODE_IDENT;
                  start_in = pos;
               end else if (decimal_char(source_byte)) begin
                  mode_in  = MODE_NUMBER;
                  start_in = pos;
               end else if (source_byte == 8'h22 || source_byte == 8'h27) begin
                  mode_in  = (source_byte == 8'h22) ? MODE_DQ : MODE_SQ;
                  start_in = pos_next;
               end else if (source_byte == "=" || source_byte == "<" ||
                            source_byte == ">" || source_byte == "!") begin
                  mode_in  = MODE_OP;
                  pend_in  = (source_byte == "=") ? 2'd0 :
                             (source_byte == "<") ? 2'd1 :
                             (source_byte == ">") ? 2'd2 : 2'd3;
                  start_in = pos;
               end else begin
                  toks[n] = make_token(single_kind(source_byte), pos, OFFSET_BITS'(1));
                  n = n + 2'd1;
               end
            end

            offset_in = pos_next;
            if (final_byte) begin
               flush_en  = 1'b1;
               flush_pos = pos_next;
               ended_in  = 1'b1;
            end
         end

         if (flush_en) begin
            unique case (mode_in)
               MODE_IDENT: begin
                  toks[n] = make_token(sslex_pkg::KIND_IDENT, start_in,
                                       span(start_in, flush_pos));
                  n = n + 2'd1;
               end
               MODE_NUMBER: begin
                  toks[n] = make_token(sslex_pkg::KIND_NUMBER, start_in,
                                       span(start_in, flush_pos));
                  n = n + 2'd1;
               end
               MODE_DQ, MODE_SQ: begin
                  toks[n] = make_token(sslex_pkg::KIND_UNTERMINATED, start_in,
                                       span(start_in, flush_pos));
                  n = n + 2'd1;
               end
               MODE_OP: begin
                  toks[n] = make_token(op_kind(pend_in, 1'b0), start_in, OFFSET_BITS'(1));
                  n = n + 2'd1;
               end
               default: begin
               end
            endcase
            mode_in = MODE_IDLE;
            toks[n] = make_token(sslex_pkg::KIND_END, flush_pos, '0);
            n = n + 2'd1;
         end
      end

      for (int i = 0; i < sslex_pkg::TOKENS_MAX; i++) begin
         toks[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
      end
   end

   assign batch.count = n;
   assign batch.tok0  = toks[0];
   assign batch.tok1  = toks[1];
   assign batch.tok2  = toks[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pend_ff   <= 2'd0;
         start_ff  <= '0;
         offset_ff <= '0;
         ended_ff  <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         ended_ff  <= ended_in;
      end
   end

endmodule

// ----- design/sslex_outq.sv -----
// Result queue for the lexer: holds the up to three tokens of one byte and
// hands them out one transaction at a time. Depends on sslex_pkg.
`timescale 1ns / 1ps

module sslex_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sslex_pkg::batch_type batch,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output sslex_pkg::token_type head,
   output logic                 can_accept
);

   sslex_pkg::token_type q_ff [0:2];
   logic [1:0]           count_ff;
   logic                 pop;

   assign pop        = (count_ff != 2'd0) && rsp_ready;
   assign rsp_valid  = (count_ff != 2'd0);
   assign head       = q_ff[0];
   assign can_accept = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (push) begin
         count_ff <= batch.count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[0] <= batch.tok0;
         q_ff[1] <= batch.tok1;
         q_ff[2] <= batch.tok2;
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
         q_ff[1] <= q_ff[2];
      end
   end

endmodule

// ----- tb/sv/token_check.sv -----
// Token checker for the script source lexer: watches the byte and token channels,
// predicts the tokens of every accepted byte and compares them in order.
// Depends on sslex_pkg for the token kind codes and the token structure.
`timescale 1ns / 1ps

module token_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_source_byte,
   input  logic        req_final_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [4:0]  rsp_token_kind,
   input  logic [15:0] rsp_token_start,
   input  logic [15:0] rsp_token_length,
   input  logic        rsp_run_last,
   output int          mismatch_count,
   output int          tokens_pending
);

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_IDENT,
      SCAN_NUMBER,
      SCAN_DQUOTE,
      SCAN_SQUOTE,
      SCAN_OPERATOR
   } scan_mode_type;

   localparam logic [1:0] CMP_EQ  = 2'd0;
   localparam logic [1:0] CMP_LT  = 2'd1;
   localparam logic [1:0] CMP_GT  = 2'd2;
   localparam logic [1:0] CMP_NOT = 2'd3;

   localparam logic [15:0] POS_MAX = 16'hFFFF;

   scan_mode_type scan_mode  = SCAN_IDLE;
   logic [1:0]    cmp_op     = CMP_EQ;
   logic [15:0]   text_start = '0;
   logic [15:0]   byte_pos   = '0;
   logic          input_done = 1'b0;

   sslex_pkg::token_type byte_tokens[$];
   sslex_pkg::token_type expected_tokens[$];

   initial begin
      mismatch_count = 0;
      tokens_pending = 0;
   end

   function automatic bit alpha_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit decimal_char(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h0A || c == 8'h09 || c == 8'h0D;
   endfunction

   function automatic logic [4:0] punct_kind(logic [7:0] c);
      case (c)
         ":":     return sslex_pkg::KIND_COLON;
         ";":     return sslex_pkg::KIND_SEMICOLON;
         "(":     return sslex_pkg::KIND_LPAREN;
         ")":     return sslex_pkg::KIND_RPAREN;
         ",":     return sslex_pkg::KIND_COMMA;
         "+":     return sslex_pkg::KIND_PLUS;
         "-":     return sslex_pkg::KIND_MINUS;
         "*":     return sslex_pkg::KIND_STAR;
         "/":     return sslex_pkg::KIND_SLASH;
         "{":     return sslex_pkg::KIND_LBRACE;
         "}":     return sslex_pkg::KIND_RBRACE;
         ".":     return sslex_pkg::KIND_DOT;
         default: return sslex_pkg::KIND_ILLEGAL;
      endcase
   endfunction

   function automatic logic [4:0] cmp_kind(logic [1:0] op, bit with_eq);
      logic [4:0] k;
      k = sslex_pkg::KIND_OP_BASE + {2'b00, op, 1'b0} + {4'b0000, with_eq};
      return k;
   endfunction

   function automatic logic [15:0] span(logic [15:0] from, logic [15:0] upto);
      return (upto > from) ? upto - from : 16'd0;
   endfunction

   function automatic logic [15:0] step_pos(logic [15:0] p);
      return (p == POS_MAX) ? p : p + 16'd1;
   endfunction

   task automatic add_token(logic [4:0] kind, logic [15:0] start, logic [15:0] length);
      sslex_pkg::token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      t.last   = 1'b0;
      byte_tokens.push_back(t);
   endtask

   task automatic start_token(logic [7:0] c, logic [15:0] pos);
      if (is_blank(c)) begin
         scan_mode = SCAN_IDLE;
      end else if (alpha_char(c)) begin
         scan_mode  = SCAN_IDENT;
         text_start = pos;
      end else if (decimal_char(c)) begin
         scan_mode  = SCAN_NUMBER;
         text_start = pos;
      end else if (c == "\"" || c == "'") begin
         scan_mode  = (c == "\"") ? SCAN_DQUOTE : SCAN_SQUOTE;
         text_start = step_pos(pos);
      end else if (c == "=" || c == "<" || c == ">" || c == "!") begin
         scan_mode  = SCAN_OPERATOR;
         cmp_op     = (c == "=") ? CMP_EQ : (c == "<") ? CMP_LT : (c == ">") ? CMP_GT : CMP_NOT;
         text_start = pos;
      end else begin
         add_token(punct_kind(c), pos, 16'd1);
      end
   endtask

   task automatic close_input(logic [15:0] end_pos);
      case (scan_mode)
         SCAN_IDENT:    add_token(sslex_pkg::KIND_IDENT, text_start,
                                  span(text_start, end_pos));
         SCAN_NUMBER:   add_token(sslex_pkg::KIND_NUMBER, text_start,
                                  span(text_start, end_pos));
         SCAN_DQUOTE,
         SCAN_SQUOTE:   add_token(sslex_pkg::KIND_UNTERMINATED, text_start,
                                  span(text_start, end_pos));
         SCAN_OPERATOR: add_token(cmp_kind(cmp_op, 1'b0), text_start, 16'd1);
         default: ;
      endcase
      scan_mode  = SCAN_IDLE;
      add_token(sslex_pkg::KIND_END, end_pos, 16'd0);
      input_done = 1'b1;
   endtask

   task automatic lex_next_byte(logic [7:0] c, logic fin);
      logic [15:0]          pos;
      bit                   redo;
      sslex_pkg::token_type t;
      pos  = byte_pos;
      redo = 1'b0;
      byte_tokens.delete();
      if (!input_done) begin
         if (c == 8'h00) begin
            close_input(pos);
         end else begin
            case (scan_mode)
               SCAN_IDENT: begin
                  if (!(alpha_char(c) || decimal_char(c))) begin
                     add_token(sslex_pkg::KIND_IDENT, text_start, span(text_start, pos));
                     redo = 1'b1;
                  end
               end
               SCAN_NUMBER: begin
                  if (!decimal_char(c)) begin
                     add_token(sslex_pkg::KIND_NUMBER, text_start, span(text_start, pos));
                     redo = 1'b1;
                  end
               end
               SCAN_DQUOTE,
               SCAN_SQUOTE: begin
                  if ((scan_mode == SCAN_DQUOTE && c == "\"") ||
                      (scan_mode == SCAN_SQUOTE && c == "'")) begin
                     add_token(sslex_pkg::KIND_STRING, text_start, span(text_start, pos));
                     scan_mode = SCAN_IDLE;
                  end
               end
               SCAN_OPERATOR: begin
                  if (c == "=") begin
                     add_token(cmp_kind(cmp_op, 1'b1), text_start, 16'd2);
                     scan_mode = SCAN_IDLE;
                  end else begin
                     add_token(cmp_kind(cmp_op, 1'b0), text_start, 16'd1);
                     redo = 1'b1;
                  end
               end
               default: redo = 1'b1;
            endcase
            if (redo) begin
               scan_mode = SCAN_IDLE;
               start_token(c, pos);
            end
            byte_pos = step_pos(pos);
            if (fin) close_input(byte_pos);
         end
      end
      for (int i = 0; i < byte_tokens.size(); i++) begin
         t      = byte_tokens[i];
         t.last = (i == byte_tokens.size() - 1);
         expected_tokens.push_back(t);
      end
   endtask

   always @(posedge clock) begin : watch
      sslex_pkg::token_type want;
      if (reset) begin
         scan_mode  = SCAN_IDLE;
         cmp_op     = CMP_EQ;
         text_start = '0;
         byte_pos   = '0;
         input_done = 1'b0;
         expected_tokens.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               mismatch_count++;
               $display("%0t: token with none expected: kind %0d start %0d length %0d last %0b",
                        $time, rsp_token_kind, rsp_token_start, rsp_token_length, rsp_run_last);
            end else begin
               want = expected_tokens.pop_front();
               if (want.kind !== rsp_token_kind || want.start !== rsp_token_start ||
                   want.length !== rsp_token_length || want.last !== rsp_run_last) begin
                  mismatch_count++;
                  $display("%0t: token mismatch: expected kind %0d start %0d length %0d last %0b",
                           $time, want.kind, want.start, want.length, want.last);
                  $display("%0t:                 actual kind %0d start %0d length %0d last %0b",
                           $time, rsp_token_kind, rsp_token_start, rsp_token_length,
                           rsp_run_last);
               end
            end
         end
         if (req_valid && req_ready) lex_next_byte(req_source_byte, req_final_byte);
      end
      tokens_pending = expected_tokens.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the script source lexer testbench: clock, reset, byte stimulus with
// bursts and pauses, a stalling token receiver and the final verdict.
// Depends on script_source_lexer_top and token_check.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int FILL_BYTES  = 10;

   typedef enum int {
      DRAIN_FULL,
      DRAIN_MOSTLY,
      DRAIN_SPARSE,
      DRAIN_BLOCKED
   } drain_type;

   typedef enum int {
      END_ZERO_IN_STRING,
      END_FLAG_IN_STRING,
      END_FLAG_AFTER_WORD,
      END_ZERO_AFTER_OP
   } ending_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_source_byte;
   logic        req_final_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic        rsp_run_last;
   int          mismatch_count;
   int          tokens_pending;

   int        cycle_count = 0;
   int        bytes_sent  = 0;
   int        burst_left  = 0;
   bit        no_gaps     = 1'b0;
   drain_type drain_mode  = DRAIN_FULL;
   int        drain_left  = 0;

   script_source_lexer_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_source_byte  (req_source_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_run_last     (rsp_run_last)
   );

   token_check tok_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_source_byte  (req_source_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_run_last     (rsp_run_last),
      .mismatch_count   (mismatch_count),
      .tokens_pending   (tokens_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (drain_left == 0) begin
         drain_mode = drain_type'($urandom_range(0, 3));
         drain_left = $urandom_range(10, 60);
      end else begin
         drain_left--;
      end
      case (drain_mode)
         DRAIN_FULL:   rsp_ready <= 1'b1;
         DRAIN_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         DRAIN_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= (drain_left % 6 == 0);
      endcase
   end

   function automatic logic [7:0] any_letter();
      int n;
      n = $urandom_range(0, 52);
      if (n < 26) return 8'("a" + n);
      if (n < 52) return 8'("A" + n - 26);
      return "_";
   endfunction

   function automatic logic [7:0] any_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] any_blank();
      case ($urandom_range(0, 3))
         0:       return 8'h20;
         1:       return 8'h0A;
         2:       return 8'h09;
         default: return 8'h0D;
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic fin);
      int gap;
      req_source_byte <= b;
      req_final_byte  <= fin;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      @(negedge clock);
      if (!no_gaps) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            gap = $urandom_range(1, 6);
            req_valid       <= 1'b0;
            req_source_byte <= 8'($urandom);
            req_final_byte  <= 1'($urandom);
            repeat (gap) @(negedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (tokens_pending != 0);
   endtask

   task automatic send_token();
      int         pick;
      int         n;
      logic [7:0] q;
      logic [7:0] c;
      string      punct;
      string      cmps;
      string      odd;
      punct = ":;(),+-*/{}.";
      cmps  = "=<>!";
      odd   = "#@$%?[]~^&|\\";
      pick  = $urandom_range(0, 99);
      if (pick < 20) begin
         push_byte(any_letter(), 1'b0);
         n = $urandom_range(0, 5);
         repeat (n) push_byte(($urandom_range(0, 2) == 0) ? any_digit() : any_letter(), 1'b0);
      end else if (pick < 32) begin
         n = $urandom_range(1, 4);
         repeat (n) push_byte(any_digit(), 1'b0);
      end else if (pick < 44) begin
         q = ($urandom_range(0, 1) != 0) ? "\"" : "'";
         push_byte(q, 1'b0);
         n = $urandom_range(0, 5);
         repeat (n) begin
            do c = 8'($urandom_range(1, 255)); while (c == q);
            push_byte(c, 1'b0);
         end
         push_byte(q, 1'b0);
      end else if (pick < 62) begin
         push_byte(cmps[$urandom_range(0, 3)], 1'b0);
         if ($urandom_range(0, 1) != 0) push_byte("=", 1'b0);
      end else if (pick < 82) begin
         push_byte(punct[$urandom_range(0, 11)], 1'b0);
      end else if (pick < 90) begin
         push_byte(any_blank(), 1'b0);
      end else if (pick < 95) begin
         if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(128, 255)), 1'b0);
         else push_byte(odd[$urandom_range(0, odd.len() - 1)], 1'b0);
      end else begin
         push_byte(8'($urandom_range(1, 255)), 1'b0);
      end
      if ($urandom_range(0, 9) < 4) push_byte(any_blank(), 1'b0);
   endtask

   initial begin : stimulus
      string      lead;
      int         mark;
      logic [7:0] c;
      ending_type ending;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_source_byte = 8'h00;
      req_final_byte  = 1'b0;
      rsp_ready       = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      lead = "_Az9 0'x'\"\"=<>!:==<=>=!=*";
      for (int i = 0; i < lead.len(); i++) push_byte(lead[i], 1'b0);
      push_byte(8'h09, 1'b0);
      push_byte(8'h0D, 1'b0);
      push_byte(8'h0A, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h01, 1'b0);
      drain_results();

      mark = bytes_sent;
      while (bytes_sent < mark + 50) send_token();
      drain_results();

      // One string is sent with no gaps between its bytes after the opening quote.
      push_byte("\"", 1'b0);
      no_gaps = 1'b1;
      repeat (FILL_BYTES) begin
         do c = 8'($urandom_range(1, 255)); while (c == "\"");
         push_byte(c, 1'b0);
      end
      push_byte("\"", 1'b0);
      no_gaps = 1'b0;

      mark = bytes_sent;
      while (bytes_sent < mark + 10) send_token();

      ending = ending_type'($urandom_range(0, 3));
      case (ending)
         END_ZERO_IN_STRING: begin
            push_byte("\"", 1'b0);
            push_byte("a", 1'b0);
            push_byte(8'h00, 1'b0);
         end
         END_FLAG_IN_STRING: begin
            push_byte("'", 1'b0);
            push_byte("q", 1'b1);
         end
         END_FLAG_AFTER_WORD: begin
            push_byte("x", 1'b0);
            push_byte(";", 1'b1);
         end
         default: begin
            push_byte("!", 1'b0);
            push_byte(8'h00, 1'b1);
         end
      endcase

      // Bytes after the end of input must be taken without any token.
      push_byte(8'h00, 1'b0);
      repeat (8) push_byte(8'($urandom_range(0, 255)), 1'($urandom));

      drain_results();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && tokens_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
